// File: hdl/bavt_pkg.sv
// Shared types, constants and saturating helpers for the bandit action-value table.
// No dependencies; every other file in hdl/ imports this package.
`timescale 1ns / 1ps
package bavt_pkg;

  localparam int VAL_W     = 48;
  localparam int FRAC_W    = 16;
  localparam int SUM_W     = 52;   // sum of up to 16 levels of one entry
  localparam int TOT_W     = 58;   // sum of up to 512 entries
  localparam int DIV_STEPS = SUM_W + FRAC_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  localparam logic signed [VAL_W-1:0] ONE_Q  = 48'sd65536;
  localparam logic signed [VAL_W-1:0] MAX48  = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [VAL_W-1:0] MIN48  = 48'sh8000_0000_0000;
  localparam logic signed [VAL_W-1:0] OPT_RESET = 48'sd655360000;

  typedef enum logic [1:0] {
    MODE_RECORD = 2'd0,
    MODE_DUMP   = 2'd1,
    MODE_MERGE  = 2'd2,
    MODE_QUERY  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0]              mode;
    logic [4:0]              action;
    logic [3:0]              level;
    logic [5:0]              entry_index;
    logic signed [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] dump_value;
    logic                    last_of_run;
    logic signed [VAL_W-1:0] asked_q;
    logic [4:0]              best_action;
    logic signed [VAL_W-1:0] best_q;
    logic signed [VAL_W-1:0] reward_total;
    logic                    status;
  } out_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_REC_CNT,
    S_REC_REW,
    S_REC_WB,
    S_MRG_RD,
    S_MRG_WB,
    S_DMP_RD,
    S_DMP_OUT,
    S_QRY_RD,
    S_QRY_SUM,
    S_QRY_DIV,
    S_QRY_WAIT,
    S_QRY_CMP,
    S_RESP
  } state_t;

  function automatic logic signed [VAL_W-1:0] sat_add(input logic signed [VAL_W-1:0] a,
                                                      input logic signed [VAL_W-1:0] b);
    logic signed [VAL_W:0] s;
    s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    if (s[VAL_W] != s[VAL_W-1]) return s[VAL_W] ? MIN48 : MAX48;
    return s[VAL_W-1:0];
  endfunction

  function automatic logic signed [VAL_W-1:0] sat_tot(input logic signed [TOT_W-1:0] t);
    logic signed [TOT_W-1:0] hi;
    logic signed [TOT_W-1:0] lo;
    hi = TOT_W'(MAX48);
    lo = TOT_W'(MIN48);
    if (t > hi) return MAX48;
    if (t < lo) return MIN48;
    return t[VAL_W-1:0];
  endfunction

endpackage

// File: hdl/bavt_mem.sv
// Single-port-write, single-port-read table memory with registered read data.
// Depends on bavt_pkg for the entry width.
`timescale 1ns / 1ps
module bavt_mem
  import bavt_pkg::*;
#(
  parameter int DEPTH  = 128,
  parameter int ADDR_W = 7
) (
  input  logic                    clk,
  input  logic                    rd_en,
  input  logic [ADDR_W-1:0]       rd_addr,
  output logic signed [VAL_W-1:0] rd_data,
  input  logic                    wr_en,
  input  logic [ADDR_W-1:0]       wr_addr,
  input  logic signed [VAL_W-1:0] wr_data
);

  logic signed [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/bavt_div.sv
// Bit-serial signed Q32.16 divider: (num << 16) / den, truncated, saturated to 48 bits.
// Depends on bavt_pkg for widths and limits.
`timescale 1ns / 1ps
module bavt_div
  import bavt_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] num,
  input  logic signed [SUM_W-1:0] den,
  output logic                    done,
  output logic signed [VAL_W-1:0] quo
);

  logic                   busy;
  logic [DCNT_W-1:0]      cnt;
  logic [DIV_STEPS-1:0]   dd;
  logic [SUM_W-1:0]       rem;
  logic [SUM_W-1:0]       dc;
  logic [VAL_W-1:0]       q;
  logic                   ovf;
  logic                   neg;
  logic [SUM_W:0]         trial;
  logic                   take;
  logic [SUM_W-1:0]       nr_abs;
  logic [SUM_W-1:0]       dc_abs;

  assign nr_abs = num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);
  assign dc_abs = den[SUM_W-1] ? SUM_W'(-den) : SUM_W'(den);
  assign trial  = {rem, dd[DIV_STEPS-1]};
  assign take   = trial >= {1'b0, dc};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DCNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dd  <= {nr_abs, {FRAC_W{1'b0}}};
      dc  <= dc_abs;
      rem <= '0;
      q   <= '0;
      ovf <= 1'b0;
      neg <= num[SUM_W-1] != den[SUM_W-1];
    end else if (busy) begin
      dd  <= dd << 1;
      rem <= take ? SUM_W'(trial - {1'b0, dc}) : trial[SUM_W-1:0];
      q   <= {q[VAL_W-2:0], take};
      ovf <= ovf | q[VAL_W-1];
    end
  end

  // Clamp: results outside the signed 48-bit range saturate; ovf marks magnitude >= 2^48.
  always_comb begin
    if (neg) begin
      if (ovf || (q[VAL_W-1] && (|q[VAL_W-2:0]))) quo = MIN48;
      else quo = VAL_W'(-$signed(q));
    end else begin
      if (ovf || q[VAL_W-1]) quo = MAX48;
      else quo = $signed(q);
    end
  end

endmodule

// File: hdl/bandit_action_value_table_top.sv
// Top level of the bandit action-value table: control sequencer, query accumulators,
// output register. Depends on bavt_pkg, bavt_mem and bavt_div.
`timescale 1ns / 1ps
//
//  Channel  | Signals                          | Beat moves
//  ---------+----------------------------------+---------------------------------
//  input    | in_valid, in_ready, in_data      | one command (in_t)
//  output   | out_valid, out_ready, out_data   | one result (out_t)
//  config   | cfg_we, cfg_data                 | optimistic value, no handshake
//
//  States: record S_REC_CNT, S_REC_REW, S_REC_WB; merge S_MRG_RD, S_MRG_WB; error
//  straight to S_RESP, which loads the output register. Dump: 2*ACTIONS beats, each
//  read in S_DMP_RD and sent in S_DMP_OUT. Query reads 2*LEVELS entries per action
//  on the single read port; a nonzero count runs the 68-step bit-serial divider.
//  Reset: after rst the sequencer zeroes all 2*ACTIONS*LEVELS table entries,
//  holding in_ready low; config writes are taken throughout.
//  Stalls: a finished result sits in the output register while the next command
//  is accepted; a dump holds between beats while out_ready is low.
//
module bandit_action_value_table_top
  import bavt_pkg::*;
#(
  parameter int ACTIONS = 16,
  parameter int LEVELS  = 4
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  in_t                     in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output out_t                    out_data,
  input  logic                    cfg_we,
  input  logic signed [VAL_W-1:0] cfg_data
);

  localparam int ROW    = 2 * ACTIONS;
  localparam int DEPTH  = ROW * LEVELS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int AW     = $clog2(ACTIONS);
  localparam int DW     = $clog2(ROW);
  localparam int KW     = $clog2(2 * LEVELS) < 1 ? 1 : $clog2(2 * LEVELS);
  localparam logic [5:0] ACT_LIM = 6'(ACTIONS);
  localparam logic [4:0] LVL_LIM = 5'(LEVELS);
  localparam logic [6:0] ENT_LIM = 7'(ROW);

  state_t state, state_next;

  in_t                     req;
  logic signed [VAL_W-1:0] opt;
  logic [ADDR_W-1:0]       clr;
  logic [DW-1:0]           di;
  logic [KW-1:0]           qk;
  logic [AW-1:0]           qa;
  logic                    resp_status;
  logic                    acc_en;
  logic                    acc_half;
  logic signed [SUM_W-1:0] cnt_acc;
  logic signed [SUM_W-1:0] rew_acc;
  logic signed [TOT_W-1:0] tot_acc;
  logic signed [VAL_W-1:0] mean;
  logic signed [VAL_W-1:0] asked;
  logic signed [VAL_W-1:0] bq;
  logic [AW-1:0]           best;

  logic                    rd_en;
  logic [ADDR_W-1:0]       rd_addr;
  logic signed [VAL_W-1:0] rd_data;
  logic                    wr_en;
  logic [ADDR_W-1:0]       wr_addr;
  logic signed [VAL_W-1:0] wr_data;

  logic                    div_start;
  logic                    div_done;
  logic signed [VAL_W-1:0] div_q;

  logic                    slot_free;
  logic                    out_load;
  logic                    in_fire;
  logic                    in_bad;
  logic [ADDR_W-1:0]       lvl_base;
  logic [ADDR_W-1:0]       qry_addr;
  logic [ADDR_W-1:0]       mrg_lo;
  logic [ADDR_W-1:0]       mrg_hi;
  logic                    better;

  bavt_mem #(
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_mem (
    .clk    (clk),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  bavt_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (rew_acc),
    .den  (cnt_acc),
    .done (div_done),
    .quo  (div_q)
  );

  assign slot_free = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  // Reject out-of-range commands up front; a bad query still runs.
  always_comb begin
    case (in_data.mode)
      MODE_RECORD: in_bad = {1'b0, in_data.action} >= ACT_LIM;
      MODE_DUMP:   in_bad = {1'b0, in_data.level} >= LVL_LIM;
      MODE_MERGE:  in_bad = ({1'b0, in_data.level} + 5'd1 >= LVL_LIM) ||
                            ({1'b0, in_data.entry_index} >= ENT_LIM);
      default:     in_bad = 1'b0;
    endcase
  end

  assign lvl_base = ADDR_W'(req.level) * ADDR_W'(ROW);
  assign mrg_lo   = lvl_base + ADDR_W'(req.entry_index);
  assign mrg_hi   = mrg_lo + ADDR_W'(ROW);
  assign qry_addr = ADDR_W'(qk >> 1) * ADDR_W'(ROW) +
                    (qk[0] ? ADDR_W'(ACTIONS) : '0) + ADDR_W'(qa);
  assign better   = (qa == '0) || (mean > bq);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:    if (clr == ADDR_W'(DEPTH - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          if (in_bad) state_next = S_RESP;
          else begin
            case (in_data.mode)
              MODE_RECORD: state_next = S_REC_CNT;
              MODE_DUMP:   state_next = S_DMP_RD;
              MODE_MERGE:  state_next = S_MRG_RD;
              default:     state_next = S_QRY_RD;
            endcase
          end
        end
      end
      S_REC_CNT:  state_next = S_REC_REW;
      S_REC_REW:  state_next = S_REC_WB;
      S_REC_WB:   state_next = S_RESP;
      S_MRG_RD:   state_next = S_MRG_WB;
      S_MRG_WB:   state_next = S_RESP;
      S_DMP_RD:   state_next = S_DMP_OUT;
      S_DMP_OUT: begin
        if (slot_free) state_next = (di == DW'(ROW - 1)) ? S_IDLE : S_DMP_RD;
      end
      S_QRY_RD:   if (qk == KW'(2 * LEVELS - 1)) state_next = S_QRY_SUM;
      S_QRY_SUM:  state_next = S_QRY_DIV;
      S_QRY_DIV:  state_next = (cnt_acc == '0) ? S_QRY_CMP : S_QRY_WAIT;
      S_QRY_WAIT: if (div_done) state_next = S_QRY_CMP;
      S_QRY_CMP:  state_next = (qa == AW'(ACTIONS - 1)) ? S_RESP : S_QRY_RD;
      S_RESP:     if (slot_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Memory ports, handshake and divider kick.
  always_comb begin
    in_ready  = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = '0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr;
      end
      S_IDLE:  in_ready = 1'b1;
      S_REC_CNT: begin
        rd_en   = 1'b1;
        rd_addr = ADDR_W'(req.action);
      end
      S_REC_REW: begin
        rd_en   = 1'b1;
        rd_addr = ADDR_W'(req.action) + ADDR_W'(ACTIONS);
        wr_en   = 1'b1;
        wr_addr = ADDR_W'(req.action);
        wr_data = sat_add(rd_data, ONE_Q);
      end
      S_REC_WB: begin
        wr_en   = 1'b1;
        wr_addr = ADDR_W'(req.action) + ADDR_W'(ACTIONS);
        wr_data = sat_add(rd_data, req.value);
      end
      S_MRG_RD: begin
        rd_en   = 1'b1;
        rd_addr = mrg_hi;
        wr_en   = 1'b1;
        wr_addr = mrg_lo;
      end
      S_MRG_WB: begin
        wr_en   = 1'b1;
        wr_addr = mrg_hi;
        wr_data = sat_add(rd_data, req.value);
      end
      S_DMP_RD: begin
        rd_en   = 1'b1;
        rd_addr = lvl_base + ADDR_W'(di);
      end
      S_DMP_OUT: out_load = slot_free;
      S_QRY_RD: begin
        rd_en   = 1'b1;
        rd_addr = qry_addr;
      end
      S_QRY_DIV: div_start = (cnt_acc != '0);
      S_RESP:    out_load = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      opt       <= OPT_RESET;
      out_valid <= 1'b0;
      acc_en    <= 1'b0;
    end else begin
      state  <= state_next;
      acc_en <= (state == S_QRY_RD);
      if (state == S_CLEAR) clr <= clr + 1'b1;
      if (cfg_we) opt <= cfg_data;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    acc_half <= qk[0];
    if (in_fire) begin
      req         <= in_data;
      resp_status <= in_bad || ((in_data.mode == MODE_QUERY) &&
                                ({1'b0, in_data.action} >= ACT_LIM));
      di      <= '0;
      qk      <= '0;
      qa      <= '0;
      cnt_acc <= '0;
      rew_acc <= '0;
      tot_acc <= '0;
      asked   <= '0;
      bq      <= '0;
      best    <= '0;
    end else begin
      // Fold the entry read last cycle into the running sums.
      if (acc_en) begin
        if (acc_half) begin
          rew_acc <= rew_acc + SUM_W'(rd_data);
          tot_acc <= tot_acc + TOT_W'(rd_data);
        end else begin
          cnt_acc <= cnt_acc + SUM_W'(rd_data);
        end
      end
      if (state == S_QRY_RD) qk <= (qk == KW'(2 * LEVELS - 1)) ? '0 : qk + 1'b1;
      if (state == S_QRY_DIV && cnt_acc == '0) mean <= opt;
      if (state == S_QRY_WAIT && div_done) mean <= div_q;
      if (state == S_QRY_CMP) begin
        if (better) begin
          bq   <= mean;
          best <= qa;
        end
        if ({1'b0, req.action} == 6'(qa)) asked <= mean;
        cnt_acc <= '0;
        rew_acc <= '0;
        qa      <= qa + 1'b1;
      end
      if (state == S_DMP_OUT && slot_free) di <= di + 1'b1;
    end
  end

  // Output register: load a dump beat or the single result.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.dump_value   <= (state == S_DMP_OUT) ? rd_data : '0;
      out_data.last_of_run  <= (state == S_RESP) || (di == DW'(ROW - 1));
      out_data.status       <= (state == S_RESP) ? resp_status : 1'b0;
      if (state == S_RESP && req.mode == MODE_QUERY) begin
        out_data.asked_q      <= asked;
        out_data.best_action  <= 5'(best);
        out_data.best_q       <= bq;
        out_data.reward_total <= sat_tot(tot_acc);
      end else begin
        out_data.asked_q      <= '0;
        out_data.best_action  <= '0;
        out_data.best_q       <= '0;
        out_data.reward_total <= '0;
      end
    end
  end

  // Never read and write one entry in the same cycle.
  a_no_rw_same: assert property (@(posedge clk) disable iff (rst)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("read and write hit the same entry");

  // Hold off commands during the clearing sweep.
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !in_ready)
    else $error("command taken while clearing");

  // Divider never finishes the cycle after a start.
  a_div_busy: assert property (@(posedge clk) disable iff (rst)
    div_start |=> !div_done)
    else $error("divider done too early");

  // An error result always closes its run.
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status) |-> out_data.last_of_run)
    else $error("error result without last flag");

endmodule
